@@ rtl/fps_pkg.sv @@
`timescale 1ns / 1ps

package fps_pkg;

  // default page area in bytes
  localparam int unsigned AREA_BYTES_DEF = 1024;

  // slot markers and erased flash value
  localparam logic [15:0] MARK_START = 16'h55AA;
  localparam logic [15:0] MARK_END   = 16'hAA55;
  localparam logic [15:0] ERASED_HW  = 16'hFFFF;

  // block size after reset, in bytes
  localparam logic [8:0] BLOCK_BYTES_RST = 9'd2;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] data;
    logic [7:0]  index;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        found;
    logic [8:0]  slot_offset;
    logic        erased;
    logic        block_done;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WSCAN,
    ST_WTEST,
    ST_WSTART,
    ST_WDATA,
    ST_WEND,
    ST_RSCAN,
    ST_RSTART,
    ST_REND,
    ST_RDATA,
    ST_RLOAD
  } state_e;

endpackage

@@ rtl/fps_ram.sv @@
`timescale 1ns / 1ps

module fps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/flash_page_settings_store_core.sv @@
`timescale 1ns / 1ps

// Settings store over one emulated flash page of AREA_BYTES/2 halfwords, kept
// as a log of blocks framed by start and end markers. Raise start with a
// request while busy is low; the result appears on rsp_o for exactly one
// cycle with done_o high and cannot be stalled, so the receiver must take it
// then. All work runs through one page memory with one write port and one
// registered read port, so timing is set by memory accesses: after reset the
// page is swept to the erased value with busy high. A read scans slots while
// start markers are present and stops at a slot without one or at the end of
// the page. A write that opens a block scans for the first erased slot, and
// when no erased slot is left erases the page and starts at its first slot;
// other writes go straight to the data. The result strobe rises in the same
// cycle that busy returns low. block_bytes is to be written through cfg_we_i
// only while the block is idle; the user must keep to this, as the block
// itself does not enforce it.

module flash_page_settings_store_core #(
  parameter int unsigned AREA_BYTES = fps_pkg::AREA_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fps_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  output logic          done_o,
  output fps_pkg::rsp_t rsp_o
);

  localparam int unsigned PAGE_HW = AREA_BYTES / 2;
  localparam int unsigned AW      = $clog2(PAGE_HW);
  // scan position wide enough for page offset plus one slot length
  localparam int unsigned SW      = ((AW > 9) ? AW : 9) + 1;
  localparam logic [SW-1:0] PAGE_S = SW'(PAGE_HW);

  fps_pkg::state_e state_q, state_d;
  fps_pkg::req_t   req_q, req_d;
  fps_pkg::rsp_t   rsp_q, rsp_d;
  logic            done_q, done_d;
  logic [8:0]      bb_q, bb_d;
  logic [8:0]      slot_q, slot_d;
  logic [8:0]      prog_q, prog_d;
  logic [SW-1:0]   s_q, s_d;
  logic [SW-1:0]   last_q, last_d;
  logic            have_q, have_d;
  logic            ers_q, ers_d;
  logic            erase_q, erase_d;
  logic [AW-1:0]   clr_q, clr_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  logic [8:0]      d_hw;
  logic [SW-1:0]   len_s;
  logic [SW-1:0]   step_s;
  logic [SW-1:0]   wr_addr;
  logic [SW-1:0]   end_addr;
  logic [SW-1:0]   rd_addr;
  logic [15:0]     rd_val;

  fps_ram #(
    .Width (16),
    .Depth (PAGE_HW)
  ) u_page (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // slot geometry from the block size
  assign d_hw     = 9'((10'(bb_q) + 10'd1) >> 1);
  assign len_s    = SW'(d_hw) + SW'(2);
  assign step_s   = s_q + len_s;
  assign end_addr = step_s - SW'(1);
  assign wr_addr  = SW'(slot_q) + SW'(1) + SW'(prog_q);
  assign rd_addr  = last_q + SW'(1) + SW'(req_q.index);

  assign busy   = (state_q != fps_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // sequencer: next state, memory port and result
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    bb_d      = bb_q;
    slot_d    = slot_q;
    prog_d    = prog_q;
    s_d       = s_q;
    last_d    = last_q;
    have_d    = have_q;
    ers_d     = ers_q;
    erase_d   = erase_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = fps_pkg::ERASED_HW;
    ram_raddr = '0;
    rd_val    = ram_rdata;

    if (cfg_we_i) begin
      bb_d = cfg_wdata_i;
    end

    case (state_q)
      // sweep the page to the erased value
      fps_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = fps_pkg::ERASED_HW;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(PAGE_HW - 1)) begin
          clr_d = '0;
          if (erase_q) begin
            erase_d = 1'b0;
            slot_d  = '0;
            state_d = fps_pkg::ST_WSTART;
          end else begin
            state_d = fps_pkg::ST_IDLE;
          end
        end
      end

      fps_pkg::ST_IDLE: begin
        if (start) begin
          req_d  = req_i;
          s_d    = '0;
          last_d = '0;
          have_d = 1'b0;
          ers_d  = 1'b0;
          if (req_i.mode == fps_pkg::MODE_READ) begin
            state_d = fps_pkg::ST_RSCAN;
          end else if (prog_q == 9'd0) begin
            state_d = fps_pkg::ST_WSCAN;
          end else begin
            state_d = fps_pkg::ST_WDATA;
          end
        end
      end

      // look for the first erased slot
      fps_pkg::ST_WSCAN: begin
        if (step_s >= PAGE_S) begin
          ers_d   = 1'b1;
          erase_d = 1'b1;
          clr_d   = '0;
          state_d = fps_pkg::ST_CLEAR;
        end else begin
          ram_raddr = s_q[AW-1:0];
          state_d   = fps_pkg::ST_WTEST;
        end
      end

      fps_pkg::ST_WTEST: begin
        if (ram_rdata == fps_pkg::ERASED_HW) begin
          slot_d  = s_q[8:0];
          state_d = fps_pkg::ST_WSTART;
        end else begin
          s_d     = step_s;
          state_d = fps_pkg::ST_WSCAN;
        end
      end

      fps_pkg::ST_WSTART: begin
        ram_we    = (SW'(slot_q) < PAGE_S);
        ram_waddr = AW'(slot_q);
        ram_wdata = fps_pkg::MARK_START;
        state_d   = fps_pkg::ST_WDATA;
      end

      fps_pkg::ST_WDATA: begin
        if (prog_q < d_hw) begin
          ram_we    = (wr_addr < PAGE_S);
          ram_waddr = wr_addr[AW-1:0];
          ram_wdata = req_q.data;
          prog_d    = prog_q + 9'd1;
        end
        state_d = fps_pkg::ST_WEND;
      end

      // close the block once all data is in, then report
      fps_pkg::ST_WEND: begin
        rsp_d.read_data   = '0;
        rsp_d.found       = 1'b1;
        rsp_d.slot_offset = slot_q;
        rsp_d.erased      = ers_q;
        rsp_d.block_done  = 1'b0;
        if (prog_q >= d_hw) begin
          ram_we           = (wr_addr < PAGE_S);
          ram_waddr        = wr_addr[AW-1:0];
          ram_wdata        = fps_pkg::MARK_END;
          prog_d           = '0;
          rsp_d.block_done = 1'b1;
        end
        done_d  = 1'b1;
        state_d = fps_pkg::ST_IDLE;
      end

      // walk slots while start markers are present
      fps_pkg::ST_RSCAN: begin
        if (step_s >= PAGE_S) begin
          state_d = fps_pkg::ST_RDATA;
        end else begin
          ram_raddr = s_q[AW-1:0];
          state_d   = fps_pkg::ST_RSTART;
        end
      end

      fps_pkg::ST_RSTART: begin
        if (ram_rdata != fps_pkg::MARK_START) begin
          state_d = fps_pkg::ST_RDATA;
        end else begin
          ram_raddr = end_addr[AW-1:0];
          state_d   = fps_pkg::ST_REND;
        end
      end

      fps_pkg::ST_REND: begin
        if (ram_rdata == fps_pkg::MARK_END) begin
          last_d = s_q;
          have_d = 1'b1;
        end
        s_d     = step_s;
        state_d = fps_pkg::ST_RSCAN;
      end

      // fetch the requested halfword of the newest complete block
      fps_pkg::ST_RDATA: begin
        if (have_q && (9'(req_q.index) < d_hw)) begin
          ram_raddr = rd_addr[AW-1:0];
          state_d   = fps_pkg::ST_RLOAD;
        end else begin
          rsp_d.read_data   = '0;
          rsp_d.found       = have_q;
          rsp_d.slot_offset = have_q ? last_q[8:0] : 9'd0;
          rsp_d.erased      = 1'b0;
          rsp_d.block_done  = 1'b0;
          done_d            = 1'b1;
          state_d           = fps_pkg::ST_IDLE;
        end
      end

      // odd block size: upper byte of the last halfword reads as zero
      fps_pkg::ST_RLOAD: begin
        if (bb_q[0] && (9'(req_q.index) == (d_hw - 9'd1))) begin
          rd_val = {8'h00, ram_rdata[7:0]};
        end
        rsp_d.read_data   = rd_val;
        rsp_d.found       = 1'b1;
        rsp_d.slot_offset = last_q[8:0];
        rsp_d.erased      = 1'b0;
        rsp_d.block_done  = 1'b0;
        done_d            = 1'b1;
        state_d           = fps_pkg::ST_IDLE;
      end

      default: begin
        state_d = fps_pkg::ST_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fps_pkg::ST_CLEAR;
      req_q   <= '0;
      rsp_q   <= '0;
      done_q  <= 1'b0;
      bb_q    <= fps_pkg::BLOCK_BYTES_RST;
      slot_q  <= '0;
      prog_q  <= '0;
      s_q     <= '0;
      last_q  <= '0;
      have_q  <= 1'b0;
      ers_q   <= 1'b0;
      erase_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      rsp_q   <= rsp_d;
      done_q  <= done_d;
      bb_q    <= bb_d;
      slot_q  <= slot_d;
      prog_q  <= prog_d;
      s_q     <= s_d;
      last_q  <= last_d;
      have_q  <= have_d;
      ers_q   <= ers_d;
      erase_q <= erase_d;
      clr_q   <= clr_d;
    end
  end

endmodule
